FILE: rtl/vtc_pkg.sv
// Shared types and constants for the vertex transform chain.
// Holds the transaction payload structs, the sequencer states and the command codes.
// No dependencies.
`default_nettype none

package vtc_pkg;

	localparam int WORD_W   = 32;
	localparam int NUM_COLS = 4;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [NUM_COLS-1:0] vec4_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_XFORM = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [1:0]  matrix_select;
		logic [3:0]  element_index;
		word_t       coefficient;
		word_t       pos_x;
		word_t       pos_y;
		word_t       pos_z;
		word_t       pos_w;
		word_t       in_red;
		word_t       in_green;
		word_t       in_blue;
		word_t       in_alpha;
	} req_t;

	typedef struct packed {
		word_t screen_x;
		word_t screen_y;
		word_t screen_z;
		word_t out_red;
		word_t out_green;
		word_t out_blue;
		word_t out_alpha;
	} rsp_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
	} dot_tag_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] row;
		word_t      value;
	} dot_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/vtc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module vtc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vtc_coef_store.sv
// Coefficient store: one RAM per matrix column, addressed by matrix and row.
// Per-entry valid bits make unwritten coefficients read as zero after reset.
// Depends on vtc_pkg and vtc_ram.
`default_nettype none

module vtc_coef_store #(
	parameter int NUM_MATRICES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [1:0]    wr_sel,
	input  wire logic [3:0]    wr_idx,
	input  wire vtc_pkg::word_t wr_data,
	input  wire logic          rd_en,
	input  wire logic [1:0]    rd_stage,
	input  wire logic [1:0]    rd_row,
	output vtc_pkg::vec4_t     rd_data
);

	localparam int DEPTH = NUM_MATRICES * 4;
	localparam int AW    = $clog2(DEPTH);

	logic          wr_ok;
	logic [4:0]    wr_full;
	logic [4:0]    rd_full;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [1:0]    wr_col;
	logic [3:0]    valid_q [DEPTH];
	logic [3:0]    vld_rd_q;
	vtc_pkg::vec4_t ram_rd;

	assign wr_ok   = wr_en && (32'(wr_sel) < NUM_MATRICES);
	assign wr_full = {1'b0, wr_sel, wr_idx[3:2]};
	assign rd_full = {1'b0, rd_stage, rd_row};
	assign wr_addr = wr_full[AW-1:0];
	assign rd_addr = rd_full[AW-1:0];
	assign wr_col  = wr_idx[1:0];

	for (genvar c = 0; c < vtc_pkg::NUM_COLS; c++) begin : g_col
		vtc_ram #(
			.WIDTH(vtc_pkg::WORD_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk    (clk),
			.wr_en  (wr_ok && (wr_col == 2'(c))),
			.wr_addr(wr_addr),
			.wr_data(wr_data),
			.rd_en  (rd_en),
			.rd_addr(rd_addr),
			.rd_data(ram_rd[c])
		);

		assign rd_data[c] = vld_rd_q[c] ? ram_rd[c] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= '0;
			end
			vld_rd_q <= '0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_addr][wr_col] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vtc_dot_unit.sv
// Shared row dot-product unit: four multipliers, a two-level adder and saturation.
// Three register stages; one matrix row enters per cycle.
// Depends on vtc_pkg.
`default_nettype none

module vtc_dot_unit #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire vtc_pkg::dot_tag_t  tag,
	input  wire vtc_pkg::vec4_t     coef,
	input  wire vtc_pkg::vec4_t     vec,
	output vtc_pkg::dot_res_t       res
);

	localparam int PW = 2 * vtc_pkg::WORD_W;

	logic signed [PW-1:0] prod_s1 [4];
	logic signed [PW:0]   pair_s2 [2];
	logic signed [PW+1:0] total;
	logic signed [PW+1:0] shifted;
	vtc_pkg::word_t       sat;
	vtc_pkg::dot_tag_t    tag_s1;
	vtc_pkg::dot_tag_t    tag_s2;

	assign total   = (PW+2)'(pair_s2[0]) + (PW+2)'(pair_s2[1]);
	assign shifted = total >>> FRAC_BITS;

	always_comb begin
		if (&shifted[PW+1:vtc_pkg::WORD_W-1] || ~|shifted[PW+1:vtc_pkg::WORD_W-1]) begin
			sat = shifted[vtc_pkg::WORD_W-1:0];
		end else if (shifted[PW+1]) begin
			sat = vtc_pkg::WORD_MIN;
		end else begin
			sat = vtc_pkg::WORD_MAX;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_s1[i] <= $signed(coef[i]) * $signed(vec[i]);
		end
		pair_s2[0] <= (PW+1)'(prod_s1[0]) + (PW+1)'(prod_s1[1]);
		pair_s2[1] <= (PW+1)'(prod_s1[2]) + (PW+1)'(prod_s1[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			res    <= '0;
		end else begin
			tag_s1    <= tag;
			tag_s2    <= tag_s1;
			res.valid <= tag_s2.valid;
			res.row   <= tag_s2.row;
			res.value <= sat;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vertex_transform_chain.sv
// Top level of the vertex transform chain: sequencer, vector registers and result register.
// Depends on vtc_pkg, vtc_coef_store and vtc_dot_unit.
//
//   channel | handshake              | payload            | role
//   req     | req_valid / req_ready  | vtc_pkg::req_t     | coefficient load or vertex transform
//   rsp     | rsp_valid / rsp_ready  | vtc_pkg::rsp_t     | screen position and color
//
// A load transaction completes in the cycle it is accepted and returns nothing.
// A transform runs min(NUM_MATRICES,4) matrix stages; each issues four rows on the shared dot
// unit and drains its read and three stages; req_ready returns once the response is loaded.
// req_ready is high only in ST_IDLE; a held response blocks loads only if ST_DONE waits on it.
// Reset clears the coefficient valid bits, so all matrices read as zero until loaded.
`default_nettype none

module vertex_transform_chain #(
	parameter int FRAC_BITS    = 16,
	parameter int NUM_MATRICES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire vtc_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output vtc_pkg::rsp_t      rsp
);

	localparam int STAGES     = (NUM_MATRICES < 4) ? NUM_MATRICES : 4;
	localparam int LAST_STAGE = STAGES - 1;

	vtc_pkg::state_t   state_q;
	vtc_pkg::state_t   state_d;
	logic [1:0]        stage_q;
	logic [1:0]        row_q;
	logic              accept;
	logic              last_res;
	logic              out_load;
	vtc_pkg::vec4_t    vec_q;
	vtc_pkg::vec4_t    nxt_q;
	vtc_pkg::vec4_t    color_q;
	vtc_pkg::vec4_t    coef;
	vtc_pkg::dot_tag_t iss_s1;
	vtc_pkg::dot_res_t dres;
	vtc_pkg::rsp_t     rsp_q;
	logic              rsp_valid_q;

	assign req_ready = (state_q == vtc_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign last_res  = dres.valid && (dres.row == 2'd3);
	assign out_load  = (state_q == vtc_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	vtc_coef_store #(
		.NUM_MATRICES(NUM_MATRICES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && (req.cmd == vtc_pkg::CMD_LOAD)),
		.wr_sel  (req.matrix_select),
		.wr_idx  (req.element_index),
		.wr_data (req.coefficient),
		.rd_en   (state_q == vtc_pkg::ST_ISSUE),
		.rd_stage(stage_q),
		.rd_row  (row_q),
		.rd_data (coef)
	);

	vtc_dot_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_dot (
		.clk   (clk),
		.arst_n(arst_n),
		.tag   (iss_s1),
		.coef  (coef),
		.vec   (vec_q),
		.res   (dres)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			vtc_pkg::ST_IDLE: begin
				if (accept && (req.cmd == vtc_pkg::CMD_XFORM)) begin
					state_d = vtc_pkg::ST_ISSUE;
				end
			end
			vtc_pkg::ST_ISSUE: begin
				if (row_q == 2'd3) begin
					state_d = vtc_pkg::ST_DRAIN;
				end
			end
			vtc_pkg::ST_DRAIN: begin
				if (last_res) begin
					state_d = (stage_q == 2'(LAST_STAGE)) ? vtc_pkg::ST_DONE
						: vtc_pkg::ST_ISSUE;
				end
			end
			vtc_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = vtc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = vtc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vtc_pkg::ST_IDLE;
			stage_q     <= '0;
			row_q       <= '0;
			iss_s1      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			iss_s1.valid <= (state_q == vtc_pkg::ST_ISSUE);
			iss_s1.row   <= row_q;
			if (accept) begin
				stage_q <= '0;
				row_q   <= '0;
			end else if (state_q == vtc_pkg::ST_ISSUE) begin
				row_q <= row_q + 2'd1;
			end else if ((state_q == vtc_pkg::ST_DRAIN) && last_res) begin
				stage_q <= stage_q + 2'd1;
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.cmd == vtc_pkg::CMD_XFORM)) begin
			vec_q   <= {req.pos_w, req.pos_z, req.pos_y, req.pos_x};
			color_q <= {req.in_alpha, req.in_blue, req.in_green, req.in_red};
		end
		if (dres.valid) begin
			nxt_q[dres.row] <= dres.value;
		end
		if ((state_q == vtc_pkg::ST_DRAIN) && last_res) begin
			vec_q <= {dres.value, nxt_q[2], nxt_q[1], nxt_q[0]};
		end
		if (out_load) begin
			rsp_q.screen_x  <= vec_q[0];
			rsp_q.screen_y  <= vec_q[1];
			rsp_q.screen_z  <= vec_q[2];
			rsp_q.out_red   <= color_q[0];
			rsp_q.out_green <= color_q[1];
			rsp_q.out_blue  <= color_q[2];
			rsp_q.out_alpha <= color_q[3];
		end
	end

`ifndef SYNTHESIS
	a_res_only_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		dres.valid |-> (state_q == vtc_pkg::ST_DRAIN))
		else $error("dot result outside of drain");

	a_xform_starts_stage0: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == vtc_pkg::CMD_XFORM)) |=>
			((state_q == vtc_pkg::ST_ISSUE) && (stage_q == 2'd0) && (row_q == 2'd0)))
		else $error("transform did not start at the first stage");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == vtc_pkg::ST_DONE))
		else $error("response raised outside of done");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.cmd == vtc_pkg::CMD_LOAD)) |=> (state_q == vtc_pkg::ST_IDLE))
		else $error("load left the idle state");
`endif

endmodule

`default_nettype wire

FILE: bench/vertex_check.sv
// Transaction checker for the vertex transform chain: watches both channels, predicts each
// transform result from its own copy of the coefficient store, and compares in order.
// Depends on vtc_pkg.
module vertex_check #(
	parameter int FRAC_BITS    = 16,
	parameter int NUM_MATRICES = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_ready,
	input  wire vtc_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_ready,
	input  wire vtc_pkg::rsp_t rsp,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int STAGES = (NUM_MATRICES < 4) ? NUM_MATRICES : 4;
	localparam logic signed [65:0] SUM_MAX = 66'sd2147483647;
	localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;

	int            matrix_words [NUM_MATRICES*16];
	vtc_pkg::rsp_t pending_vertices [$];
	vtc_pkg::rsp_t want;

	// Four exact products summed at full width, floored by the fraction bits, then saturated.
	function automatic int row_dot(int base, int vec[4]);
		logic signed [65:0] acc;
		acc = '0;
		for (int i = 0; i < 4; i++) begin
			acc = acc + longint'(matrix_words[base+i]) * longint'(vec[i]);
		end
		acc = acc >>> FRAC_BITS;
		if (acc > SUM_MAX) begin
			acc = SUM_MAX;
		end else if (acc < SUM_MIN) begin
			acc = SUM_MIN;
		end
		return int'(acc[31:0]);
	endfunction

	function automatic vtc_pkg::rsp_t transform_vertex(vtc_pkg::req_t item);
		int            vec [4];
		int            nxt [4];
		vtc_pkg::rsp_t res;
		vec = '{item.pos_x, item.pos_y, item.pos_z, item.pos_w};
		for (int s = 0; s < STAGES; s++) begin
			for (int r = 0; r < 4; r++) begin
				nxt[r] = row_dot(s*16 + r*4, vec);
			end
			vec = nxt;
		end
		res.screen_x  = vec[0];
		res.screen_y  = vec[1];
		res.screen_z  = vec[2];
		res.out_red   = item.in_red;
		res.out_green = item.in_green;
		res.out_blue  = item.in_blue;
		res.out_alpha = item.in_alpha;
		return res;
	endfunction

	task automatic check_field(string name, vtc_pkg::word_t expected, vtc_pkg::word_t actual);
		if (expected !== actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (matrix_words[i]) begin
				matrix_words[i] = 0;
			end
			pending_vertices.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_vertices.size() == 0) begin
					$error("result transaction arrived with no transform outstanding");
					mismatches++;
				end else begin
					want = pending_vertices.pop_front();
					check_field("screen_x", want.screen_x, rsp.screen_x);
					check_field("screen_y", want.screen_y, rsp.screen_y);
					check_field("screen_z", want.screen_z, rsp.screen_z);
					check_field("out_red", want.out_red, rsp.out_red);
					check_field("out_green", want.out_green, rsp.out_green);
					check_field("out_blue", want.out_blue, rsp.out_blue);
					check_field("out_alpha", want.out_alpha, rsp.out_alpha);
				end
			end
			if (req_valid && req_ready) begin
				if (req.cmd == vtc_pkg::CMD_LOAD) begin
					if (req.matrix_select < NUM_MATRICES) begin
						matrix_words[req.matrix_select*16 + req.element_index] = req.coefficient;
					end
				end else begin
					pending_vertices.push_back(transform_vertex(req));
				end
			end
			outstanding = pending_vertices.size();
		end
	end

endmodule

FILE: bench/tb.sv
// Testbench top for the vertex transform chain: clock, reset, coefficient loads and vertex
// transforms with random gaps and stalls, and the verdict.
// Depends on vtc_pkg, vertex_transform_chain and vertex_check.
module tb;

	localparam int FRAC         = 16;
	localparam int MATS         = 4;
	localparam int ITEM_TARGET  = 1360;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 500000;

	localparam logic [1:0] MAT_MODEL      = 2'd0;
	localparam logic [1:0] MAT_VIEW       = 2'd1;
	localparam logic [1:0] MAT_PROJECTION = 2'd2;
	localparam logic [1:0] MAT_VIEWPORT   = 2'd3;

	localparam int KIND_NEAR_UNIT = 0;
	localparam int KIND_MODERATE  = 1;
	localparam int KIND_FULL      = 2;
	localparam int KIND_EXTREME   = 3;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          rsp_ready = 1'b0;
	vtc_pkg::req_t req = '0;
	logic          req_ready;
	logic          rsp_valid;
	vtc_pkg::rsp_t rsp;
	int            mismatches;
	int            outstanding;
	int            cycle_count = 0;
	int            items_sent = 0;
	bit            calm = 1'b0;
	bit            choke_request = 1'b0;
	bit            choke_done = 1'b0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	vertex_transform_chain #(
		.FRAC_BITS   (FRAC),
		.NUM_MATRICES(MATS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	vertex_check #(
		.FRAC_BITS   (FRAC),
		.NUM_MATRICES(MATS)
	) vcheck (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic vtc_pkg::word_t pick_extreme();
		case ($urandom_range(5))
			0: return vtc_pkg::WORD_MAX;
			1: return vtc_pkg::WORD_MIN;
			2: return 32'sd0;
			3: return -32'sd1;
			4: return 32'sd1;
			default: return 32'sh10000;
		endcase
	endfunction

	function automatic vtc_pkg::word_t moderate(int unsigned span);
		return vtc_pkg::word_t'($urandom_range(2*span)) - vtc_pkg::word_t'(span);
	endfunction

	function automatic vtc_pkg::req_t random_item();
		vtc_pkg::req_t item;
		item.cmd           = 1'($urandom_range(1));
		item.matrix_select = 2'($urandom_range(3));
		item.element_index = 4'($urandom_range(15));
		item.coefficient   = $urandom();
		item.pos_x         = $urandom();
		item.pos_y         = $urandom();
		item.pos_z         = $urandom();
		item.pos_w         = $urandom();
		item.in_red        = $urandom();
		item.in_green      = $urandom();
		item.in_blue       = $urandom();
		item.in_alpha      = $urandom();
		return item;
	endfunction

	function automatic int pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 50) return KIND_NEAR_UNIT;
		if (r < 75) return KIND_MODERATE;
		if (r < 88) return KIND_FULL;
		return KIND_EXTREME;
	endfunction

	function automatic vtc_pkg::word_t pick_coef(int kind, int idx);
		bit diag;
		diag = (idx % 5) == 0;
		case (kind)
			KIND_NEAR_UNIT: return diag ? 32'sh10000 + moderate(32'h1000) : moderate(32'h800);
			KIND_MODERATE:  return moderate(32'h30000);
			KIND_FULL:      return $urandom();
			default:        return pick_extreme();
		endcase
	endfunction

	function automatic vtc_pkg::req_t make_load(logic [1:0] sel, logic [3:0] idx,
		vtc_pkg::word_t value);
		vtc_pkg::req_t item;
		item = random_item();
		item.cmd           = vtc_pkg::CMD_LOAD;
		item.matrix_select = sel;
		item.element_index = idx;
		item.coefficient   = value;
		return item;
	endfunction

	function automatic vtc_pkg::req_t make_vertex();
		vtc_pkg::req_t item;
		int            r;
		item = random_item();
		item.cmd = vtc_pkg::CMD_XFORM;
		r = $urandom_range(99);
		if (r < 60) begin
			item.pos_x = moderate(32'h400_0000);
			item.pos_y = moderate(32'h400_0000);
			item.pos_z = moderate(32'h400_0000);
			item.pos_w = ($urandom_range(3) == 0) ? moderate(32'h40000) : 32'sh10000;
		end else if (r >= 85) begin
			item.pos_x = pick_extreme();
			item.pos_y = pick_extreme();
			item.pos_z = pick_extreme();
			item.pos_w = pick_extreme();
		end
		if ($urandom_range(9) == 0) begin
			item.in_red   = pick_extreme();
			item.in_alpha = pick_extreme();
		end
		return item;
	endfunction

	task automatic send_item(vtc_pkg::req_t item);
		if (!calm) begin
			while ($urandom_range(99) < 27) begin
				req_valid = 1'b0;
				@(negedge clk);
			end
		end
		req       = item;
		req_valid = 1'b1;
		do begin
			@(posedge clk);
		end while (!req_ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic fill_matrix(logic [1:0] sel, int kind);
		for (int idx = 0; idx < 16; idx++) begin
			send_item(make_load(sel, 4'(idx), pick_coef(kind, idx)));
		end
	endtask

	// Result side: random stalls, one long hold-off on request, none during the calm stretch.
	initial begin
		forever begin
			@(negedge clk);
			if (choke_request && !choke_done) begin
				rsp_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				choke_done = 1'b1;
			end
			rsp_ready = calm || ($urandom_range(99) >= 27);
		end
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		vtc_pkg::req_t item;
		int            iter;
		int            r;
		iter = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// All matrices still read as zero, so the position collapses while color passes.
		item = make_vertex();
		item.pos_x    = vtc_pkg::WORD_MAX;
		item.pos_y    = vtc_pkg::WORD_MIN;
		item.pos_z    = 32'sd0;
		item.pos_w    = -32'sd1;
		item.in_red   = vtc_pkg::WORD_MIN;
		item.in_green = vtc_pkg::WORD_MAX;
		item.in_blue  = 32'sd0;
		item.in_alpha = -32'sd1;
		send_item(item);
		send_item(make_load(MAT_MODEL, 4'd0, vtc_pkg::WORD_MAX));
		send_item(make_load(MAT_VIEW, 4'd15, vtc_pkg::WORD_MIN));
		send_item(make_load(MAT_PROJECTION, 4'd5, 32'sh10000));
		send_item(make_load(MAT_VIEWPORT, 4'd10, -32'sd1));
		send_item(make_vertex());
		item = make_vertex();
		item.pos_x = vtc_pkg::WORD_MAX;
		item.pos_w = vtc_pkg::WORD_MIN;
		send_item(item);

		while (items_sent < ITEM_TARGET) begin
			calm = (iter >= 40) && (iter < 70);
			if (iter == 20) begin
				// The held result blocks further transforms until the receiver lets go.
				choke_request = 1'b1;
				repeat (6) send_item(make_vertex());
			end
			r = $urandom_range(99);
			if (iter == 0 || r < 8) begin
				fill_matrix(MAT_MODEL, pick_kind());
				fill_matrix(MAT_VIEW, pick_kind());
				fill_matrix(MAT_PROJECTION, pick_kind());
				fill_matrix(MAT_VIEWPORT, pick_kind());
			end else if (r < 35) begin
				fill_matrix(2'($urandom_range(3)), pick_kind());
			end else if (r < 45) begin
				repeat ($urandom_range(1, 4)) begin
					send_item(make_load(2'($urandom_range(3)), 4'($urandom_range(15)),
						pick_coef(pick_kind(), $urandom_range(15))));
				end
			end else begin
				repeat ($urandom_range(1, 6)) send_item(make_vertex());
			end
			iter++;
		end
		calm = 1'b0;
		req_valid = 1'b0;

		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/vtc_pkg.sv
rtl/vtc_ram.sv
rtl/vtc_coef_store.sv
rtl/vtc_dot_unit.sv
rtl/vertex_transform_chain.sv
bench/vertex_check.sv
bench/tb.sv
